FILE: hdl/fpp_pkg.sv
// fpp_pkg: shared types and constants for the fen position parser
// no dependencies; used by fpp_front, fpp_back and fen_position_parser
`timescale 1ns / 1ps

package fpp_pkg;

    localparam int FILE_COUNT  = 8;
    localparam int RANK_COUNT  = 8;
    localparam int FILE_MAX    = 15;
    localparam int CASTLE_LEN  = 4;
    localparam int EP_LEN      = 2;
    localparam int DIGIT_MAX   = 2;
    localparam int DEC_BASE    = 10;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_W     = 8'h77;

    typedef struct packed {
        logic [7:0] text_char;
        logic       final_char;
    } text_item_t;

    typedef struct packed {
        logic [3:0]  rank_number;
        logic [63:0] rank_pieces;
        logic        black_to_move;
        logic [31:0] castling_text;
        logic [15:0] en_passant_text;
        logic [6:0]  halfmove_count;
        logic [6:0]  fullmove_count;
        logic        last_record;
    } record_item_t;

    typedef enum logic [2:0] {
        CLS_SPACE,
        CLS_SLASH,
        CLS_PIECE,
        CLS_DIGIT,
        CLS_OTHER
    } char_class_t;

    // one classified byte as it sits in the queue
    typedef struct packed {
        logic [7:0]  ch;
        logic        fin;
        char_class_t cls;
        logic [3:0]  digit;
        logic        is_w;
    } op_t;

    typedef enum logic [2:0] {
        SEC_PLACE,
        SEC_SIDE,
        SEC_GAP,
        SEC_CASTLE,
        SEC_EP,
        SEC_HALF,
        SEC_FULL
    } section_t;

    typedef enum logic {
        BK_RUN,
        BK_EMIT
    } back_state_t;

endpackage

FILE: hdl/fen_position_parser.sv
// fen_position_parser: top level, front classifier and queue feeding the back end
// depends on fpp_pkg, fpp_front and fpp_back
`timescale 1ns / 1ps

// Takes a FEN string one byte per transfer on text, with final_char set on the
// last byte, and answers with eight rank records on record, rank 8 first, each
// carrying the rank's eight piece letters and the side, castling, en passant and
// move-number fields. Bytes are taken one per cycle while text is not stalled:
// the front classifies each byte into a two-entry queue and the back end applies
// one queued byte per cycle outside the record burst. Once the final byte is
// applied, the records load one per cycle while the output is not stalled; in
// that burst the back end pops nothing, so text stalls once both queue entries
// are filled. All string state clears as the last record loads, for the next string.

module fen_position_parser
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  text_valid,
    output logic                  text_stall,
    input  fpp_pkg::text_item_t   text,
    output logic                  record_valid,
    input  logic                  record_stall,
    output fpp_pkg::record_item_t record
);

    logic         op_valid;
    logic         op_take;
    fpp_pkg::op_t op;

    fpp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text       (text),
        .op_valid   (op_valid),
        .op         (op),
        .op_take    (op_take)
    );

    fpp_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .op_valid     (op_valid),
        .op           (op),
        .op_take      (op_take),
        .record_valid (record_valid),
        .record_stall (record_stall),
        .record       (record)
    );

endmodule

FILE: hdl/fpp_front.sv
// fpp_front: accepts text bytes, classifies them and queues them for the back end
// depends on fpp_pkg
`timescale 1ns / 1ps

module fpp_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               text_valid,
    output logic               text_stall,
    input  fpp_pkg::text_item_t text,
    output logic               op_valid,
    output fpp_pkg::op_t       op,
    input  logic               op_take
);

    fpp_pkg::op_t                       op_in;
    logic [7:0]                         digit_diff;
    logic                               push;
    fpp_pkg::op_t                       mem_reg [fpp_pkg::QUEUE_DEPTH];
    logic [fpp_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg;
    logic [fpp_pkg::QUEUE_PTR_W-1:0]    wr_ptr_next;
    logic [fpp_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg;
    logic [fpp_pkg::QUEUE_PTR_W-1:0]    rd_ptr_next;
    logic [fpp_pkg::QUEUE_CNT_W-1:0]    count_reg;
    logic [fpp_pkg::QUEUE_CNT_W-1:0]    count_next;

    // byte classifier
    always_comb
    begin
        digit_diff  = text.text_char - fpp_pkg::CHAR_ZERO;
        op_in.ch    = text.text_char;
        op_in.fin   = text.final_char;
        op_in.digit = digit_diff[3:0];
        op_in.is_w  = (text.text_char == fpp_pkg::CHAR_W);
        unique case (text.text_char) inside
            fpp_pkg::CHAR_SPACE:
                op_in.cls = fpp_pkg::CLS_SPACE;
            fpp_pkg::CHAR_SLASH:
                op_in.cls = fpp_pkg::CLS_SLASH;
            "P", "N", "B", "R", "Q", "K", "p", "n", "b", "r", "q", "k":
                op_in.cls = fpp_pkg::CLS_PIECE;
            [fpp_pkg::CHAR_ZERO:fpp_pkg::CHAR_NINE]:
                op_in.cls = fpp_pkg::CLS_DIGIT;
            default:
                op_in.cls = fpp_pkg::CLS_OTHER;
        endcase
    end

    assign text_stall = (count_reg == fpp_pkg::QUEUE_CNT_W'(fpp_pkg::QUEUE_DEPTH));
    assign push       = text_valid && !text_stall;
    assign op_valid   = (count_reg != '0);
    assign op         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == fpp_pkg::QUEUE_PTR_W'(fpp_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (op_take)
        begin
            rd_ptr_next = (rd_ptr_reg == fpp_pkg::QUEUE_PTR_W'(fpp_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !op_take)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && op_take)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= op_in;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= fpp_pkg::QUEUE_CNT_W'(fpp_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push && !op_take |=> count_reg == $past(count_reg) + 1'b1)
        else $error("transfer in without pop did not grow the queue");

    a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        op_take |-> count_reg != '0)
        else $error("pop from empty queue");

endmodule

FILE: hdl/fpp_back.sv
// fpp_back: applies queued bytes to the position state and emits rank records
// depends on fpp_pkg
`timescale 1ns / 1ps

module fpp_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  op_valid,
    input  fpp_pkg::op_t          op,
    output logic                  op_take,
    output logic                  record_valid,
    input  logic                  record_stall,
    output fpp_pkg::record_item_t record
);

    fpp_pkg::back_state_t  state_reg;
    fpp_pkg::back_state_t  state_next;
    fpp_pkg::section_t     section_reg;
    fpp_pkg::section_t     section_next;
    logic [3:0]            file_pos_reg;
    logic [3:0]            file_pos_next;
    logic [3:0]            rank_pos_reg;
    logic [3:0]            rank_pos_next;
    logic [63:0]           squares_reg [fpp_pkg::RANK_COUNT];
    logic [63:0]           squares_next [fpp_pkg::RANK_COUNT];
    logic                  black_reg;
    logic                  black_next;
    logic [31:0]           castling_reg;
    logic [31:0]           castling_next;
    logic [15:0]           ep_reg;
    logic [15:0]           ep_next;
    logic [2:0]            char_index_reg;
    logic [2:0]            char_index_next;
    logic [6:0]            half_reg;
    logic [6:0]            half_next;
    logic [6:0]            full_reg;
    logic [6:0]            full_next;
    logic [1:0]            digit_count_reg;
    logic [1:0]            digit_count_next;
    logic [2:0]            emit_cnt_reg;
    logic [2:0]            emit_cnt_next;
    logic                  record_valid_reg;
    logic                  record_valid_next;
    fpp_pkg::record_item_t record_reg;
    fpp_pkg::record_item_t record_next;
    logic                  load;
    logic [2:0]            row_idx;
    logic [4:0]            file_sum;
    logic [6:0]            num_src;
    logic [10:0]           num_calc;
    logic                  digit_ok;

    assign op_take      = (state_reg == fpp_pkg::BK_RUN) && op_valid;
    assign load         = (state_reg == fpp_pkg::BK_EMIT) && (!record_valid_reg || !record_stall);
    assign record_valid = record_valid_reg;
    assign record       = record_reg;

    // shared helpers for placement and number fields
    assign row_idx  = 3'(rank_pos_reg - 4'd1);
    assign file_sum = {1'b0, file_pos_reg} + {1'b0, op.digit};
    assign num_src  = (section_reg == fpp_pkg::SEC_HALF) ? half_reg : full_reg;
    assign num_calc = 11'(num_src) * 11'(fpp_pkg::DEC_BASE) + 11'(op.digit);
    assign digit_ok = (op.cls == fpp_pkg::CLS_DIGIT)
                      && (digit_count_reg < 2'(fpp_pkg::DIGIT_MAX));

    always_comb
    begin
        state_next        = state_reg;
        section_next      = section_reg;
        file_pos_next     = file_pos_reg;
        rank_pos_next     = rank_pos_reg;
        squares_next      = squares_reg;
        black_next        = black_reg;
        castling_next     = castling_reg;
        ep_next           = ep_reg;
        char_index_next   = char_index_reg;
        half_next         = half_reg;
        full_next         = full_reg;
        digit_count_next  = digit_count_reg;
        emit_cnt_next     = emit_cnt_reg;
        record_valid_next = record_valid_reg && record_stall;
        record_next       = record_reg;

        unique case (state_reg)
            fpp_pkg::BK_RUN:
            begin
                if (op_take)
                begin
                    unique case (section_reg)
                        fpp_pkg::SEC_PLACE:
                        begin
                            if (op.cls == fpp_pkg::CLS_SPACE)
                            begin
                                section_next = fpp_pkg::SEC_SIDE;
                            end
                            else if (op.cls == fpp_pkg::CLS_SLASH)
                            begin
                                if (rank_pos_reg != 4'd0)
                                begin
                                    rank_pos_next = rank_pos_reg - 4'd1;
                                end
                                file_pos_next = 4'd0;
                            end
                            else if (op.cls == fpp_pkg::CLS_PIECE)
                            begin
                                // off-board placements are dropped
                                if (file_pos_reg < 4'(fpp_pkg::FILE_COUNT)
                                    && rank_pos_reg != 4'd0)
                                begin
                                    squares_next[row_idx][8*file_pos_reg[2:0] +: 8] = op.ch;
                                end
                                if (file_pos_reg != 4'(fpp_pkg::FILE_MAX))
                                begin
                                    file_pos_next = file_pos_reg + 4'd1;
                                end
                            end
                            else if (op.cls == fpp_pkg::CLS_DIGIT)
                            begin
                                file_pos_next = (file_sum > 5'(fpp_pkg::FILE_MAX))
                                                ? 4'(fpp_pkg::FILE_MAX) : file_sum[3:0];
                            end
                        end
                        fpp_pkg::SEC_SIDE:
                        begin
                            black_next   = !op.is_w;
                            section_next = fpp_pkg::SEC_GAP;
                        end
                        fpp_pkg::SEC_GAP:
                        begin
                            if (op.cls == fpp_pkg::CLS_SPACE)
                            begin
                                section_next    = fpp_pkg::SEC_CASTLE;
                                char_index_next = 3'd0;
                            end
                        end
                        fpp_pkg::SEC_CASTLE:
                        begin
                            if (op.cls == fpp_pkg::CLS_SPACE)
                            begin
                                section_next    = fpp_pkg::SEC_EP;
                                char_index_next = 3'd0;
                            end
                            else if (char_index_reg < 3'(fpp_pkg::CASTLE_LEN))
                            begin
                                castling_next[8*char_index_reg[1:0] +: 8] =
                                    castling_reg[8*char_index_reg[1:0] +: 8] | op.ch;
                                char_index_next = char_index_reg + 3'd1;
                            end
                        end
                        fpp_pkg::SEC_EP:
                        begin
                            if (op.cls == fpp_pkg::CLS_SPACE)
                            begin
                                section_next     = fpp_pkg::SEC_HALF;
                                digit_count_next = 2'd0;
                            end
                            else if (char_index_reg < 3'(fpp_pkg::EP_LEN))
                            begin
                                ep_next[8*char_index_reg[0] +: 8] =
                                    ep_reg[8*char_index_reg[0] +: 8] | op.ch;
                                char_index_next = char_index_reg + 3'd1;
                            end
                        end
                        fpp_pkg::SEC_HALF:
                        begin
                            if (op.cls == fpp_pkg::CLS_SPACE)
                            begin
                                section_next     = fpp_pkg::SEC_FULL;
                                digit_count_next = 2'd0;
                            end
                            else if (digit_ok)
                            begin
                                half_next        = num_calc[6:0];
                                digit_count_next = digit_count_reg + 2'd1;
                            end
                        end
                        fpp_pkg::SEC_FULL:
                        begin
                            if (digit_ok)
                            begin
                                full_next        = num_calc[6:0];
                                digit_count_next = digit_count_reg + 2'd1;
                            end
                        end
                        default:
                        begin
                            section_next = section_reg;
                        end
                    endcase
                    if (op.fin)
                    begin
                        state_next    = fpp_pkg::BK_EMIT;
                        emit_cnt_next = 3'd0;
                    end
                end
            end
            fpp_pkg::BK_EMIT:
            begin
                if (load)
                begin
                    record_valid_next           = 1'b1;
                    record_next.rank_number     = 4'(fpp_pkg::RANK_COUNT) - {1'b0, emit_cnt_reg};
                    record_next.rank_pieces     = squares_reg[~emit_cnt_reg];
                    record_next.black_to_move   = black_reg;
                    record_next.castling_text   = castling_reg;
                    record_next.en_passant_text = ep_reg;
                    record_next.halfmove_count  = half_reg;
                    record_next.fullmove_count  = full_reg;
                    record_next.last_record     =
                        (emit_cnt_reg == 3'(fpp_pkg::RANK_COUNT - 1));
                    emit_cnt_next = emit_cnt_reg + 3'd1;
                    if (emit_cnt_reg == 3'(fpp_pkg::RANK_COUNT - 1))
                    begin
                        // record register holds its own copy, so the string state can go
                        state_next       = fpp_pkg::BK_RUN;
                        section_next     = fpp_pkg::SEC_PLACE;
                        file_pos_next    = 4'd0;
                        rank_pos_next    = 4'(fpp_pkg::RANK_COUNT);
                        squares_next     = '{default: '0};
                        black_next       = 1'b0;
                        castling_next    = '0;
                        ep_next          = '0;
                        char_index_next  = 3'd0;
                        half_next        = '0;
                        full_next        = '0;
                        digit_count_next = 2'd0;
                    end
                end
            end
            default:
            begin
                state_next = fpp_pkg::BK_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= fpp_pkg::BK_RUN;
            section_reg      <= fpp_pkg::SEC_PLACE;
            file_pos_reg     <= 4'd0;
            rank_pos_reg     <= 4'(fpp_pkg::RANK_COUNT);
            squares_reg      <= '{default: '0};
            black_reg        <= 1'b0;
            castling_reg     <= '0;
            ep_reg           <= '0;
            char_index_reg   <= 3'd0;
            half_reg         <= '0;
            full_reg         <= '0;
            digit_count_reg  <= 2'd0;
            emit_cnt_reg     <= 3'd0;
            record_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            section_reg      <= section_next;
            file_pos_reg     <= file_pos_next;
            rank_pos_reg     <= rank_pos_next;
            squares_reg      <= squares_next;
            black_reg        <= black_next;
            castling_reg     <= castling_next;
            ep_reg           <= ep_next;
            char_index_reg   <= char_index_next;
            half_reg         <= half_next;
            full_reg         <= full_next;
            digit_count_reg  <= digit_count_next;
            emit_cnt_reg     <= emit_cnt_next;
            record_valid_reg <= record_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        record_reg <= record_next;
    end

    a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rank_pos_reg <= 4'(fpp_pkg::RANK_COUNT))
        else $error("rank position beyond rank 8");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        load && emit_cnt_reg == 3'(fpp_pkg::RANK_COUNT - 1)
        |=> state_reg == fpp_pkg::BK_RUN && section_reg == fpp_pkg::SEC_PLACE
            && rank_pos_reg == 4'(fpp_pkg::RANK_COUNT) && record_reg.last_record)
        else $error("state not cleared after last record");

    a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fpp_pkg::BK_EMIT && record_valid_reg && record_stall
        |=> $stable(emit_cnt_reg))
        else $error("record counter advanced while output stalled");

endmodule
